>>> design/bmp_pkg.sv
// Shared types and constants for the bitmap pixel stream parser.
// Used by the result interface, the front, the command queue, the back and the top level.
`timescale 1ns / 1ps
`default_nettype none

package bmp_pkg;

  localparam int COORD_W = 12;
  localparam int CHAN_W  = 8;

  // Result status codes.
  localparam logic [1:0] ST_PIXEL       = 2'd0;
  localparam logic [1:0] ST_BAD_SIG     = 2'd1;
  localparam logic [1:0] ST_UNSUPPORTED = 2'd2;

  // Depth of the queue between front and back.
  localparam int CMD_FIFO_DEPTH = 4;
  localparam int CMD_PTR_W      = $clog2(CMD_FIFO_DEPTH);

  typedef enum logic [1:0] {
    CMD_PIX  = 2'd0,
    CMD_WARN = 2'd1,
    CMD_ERR  = 2'd2
  } cmd_kind_t;

  // One classified byte handed from the front to the back.
  typedef struct packed {
    cmd_kind_t          kind;
    logic [CHAN_W-1:0]  data;
    logic [1:0]         ch;
    logic               done;
    logic               four;
    logic               last;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
  } cmd_t;

endpackage

`default_nettype wire

>>> design/bmp_in_if.sv
// Input channel of the parser: one file byte per beat.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface bmp_in_if ();
  logic       valid;
  logic       ready;
  logic [7:0] file_byte;
  logic       start_of_file;

  modport source (output valid, output file_byte, output start_of_file, input ready);
  modport sink   (input valid, input file_byte, input start_of_file, output ready);
endinterface

`default_nettype wire

>>> design/bmp_out_if.sv
// Result channel of the parser: one pixel, warning or error per beat.
// Depends on bmp_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface bmp_out_if import bmp_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic [COORD_W-1:0] row;
  logic [COORD_W-1:0] column;
  logic [CHAN_W-1:0]  red;
  logic [CHAN_W-1:0]  green;
  logic [CHAN_W-1:0]  blue;
  logic [CHAN_W-1:0]  alpha;
  logic               has_alpha;
  logic               last_pixel;

  modport source (output valid, output status, output row, output column, output red,
                  output green, output blue, output alpha, output has_alpha,
                  output last_pixel, input ready);
  modport sink   (input valid, input status, input row, input column, input red,
                  input green, input blue, input alpha, input has_alpha,
                  input last_pixel, output ready);
endinterface

`default_nettype wire

>>> design/bmp_front.sv
// Front of the parser: accepts file bytes, parses the header and tracks pixel position.
// Depends on bmp_pkg and bmp_in_if; emits classified commands toward the queue.
`timescale 1ns / 1ps
`default_nettype none

module bmp_front import bmp_pkg::*; #(
  parameter int MAX_DIM = 4096
) (
  input  logic       clk,
  input  logic       rst_n,
  bmp_in_if.sink     in_ch,
  output logic       cmd_valid,
  input  logic       cmd_ready,
  output cmd_t       cmd
);

  localparam int CW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

  localparam logic [7:0] SIG_B = 8'd66;
  localparam logic [7:0] SIG_M = 8'd77;
  localparam logic [7:0] SIG_A = 8'd65;
  localparam logic [7:0] SIG_C = 8'd67;
  localparam logic [7:0] SIG_I = 8'd73;
  localparam logic [7:0] SIG_P = 8'd80;
  localparam logic [7:0] SIG_T = 8'd84;

  typedef enum logic [3:0] {
    PH_HEADER = 4'b0001,
    PH_PIXEL  = 4'b0010,
    PH_PAD    = 4'b0100,
    PH_DONE   = 4'b1000
  } phase_t;

  function automatic logic sig_ok(input logic [7:0] a, input logic [7:0] b);
    sig_ok = (a == SIG_B && b == SIG_M) || (a == SIG_B && b == SIG_A) ||
             (a == SIG_C && b == SIG_I) || (a == SIG_C && b == SIG_P) ||
             (a == SIG_I && b == SIG_C) || (a == SIG_P && b == SIG_T);
  endfunction

  phase_t        phase_r, phase_nxt, phase_c;
  logic [31:0]   pos_r, pos_nxt, pos_c;
  logic [7:0]    sig_r, sig_nxt;
  logic [31:0]   offset_r, offset_nxt;
  logic [31:0]   width_r, width_nxt;
  logic [31:0]   height_r, height_nxt;
  logic [4:0]    bpp_r, bpp_nxt, bpp_now;
  logic [CW-1:0] row_r, row_nxt;
  logic [CW-1:0] col_r, col_nxt;
  logic [CW:0]   col_inc;
  logic [1:0]    ch_r, ch_nxt;
  logic          four_r, four_nxt;
  logic [1:0]    pad_r, pad_nxt;
  logic [1:0]    lane;
  logic          accept, sof, hdr_end, bad_hdr, empty_img, col_wrap, last, done;
  logic [7:0]    b;

  assign in_ch.ready = cmd_ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign sof         = in_ch.start_of_file;
  assign b           = in_ch.file_byte;

  // A start mark restarts the header walk on this very byte.
  assign phase_c = sof ? PH_HEADER : phase_r;
  assign pos_c   = sof ? '0 : pos_r;

  assign bpp_now   = (pos_c == 32'd28) ? b[7:3] : bpp_r;
  // The header spans max(offset, 29) bytes; the offset is complete well before byte 28.
  assign hdr_end   = (pos_c >= 32'd28) && (({1'b0, pos_c} + 33'd1) >= {1'b0, offset_r});
  assign bad_hdr   = (bpp_now != 5'd3 && bpp_now != 5'd4) ||
                     (width_r > 32'(MAX_DIM)) || (height_r > 32'(MAX_DIM));
  assign empty_img = (width_r == '0) || (height_r == '0);

  assign col_inc  = {1'b0, col_r} + 1'b1;
  assign col_wrap = 32'(col_inc) >= width_r;
  assign last     = (row_r == '0) && (32'(col_inc) == width_r);
  assign done     = four_r ? (ch_r == 2'd3) : (ch_r == 2'd2);

  always_comb begin
    phase_nxt  = phase_r;
    pos_nxt    = pos_r;
    sig_nxt    = sig_r;
    offset_nxt = offset_r;
    width_nxt  = width_r;
    height_nxt = height_r;
    bpp_nxt    = bpp_r;
    row_nxt    = row_r;
    col_nxt    = col_r;
    ch_nxt     = ch_r;
    four_nxt   = four_r;
    pad_nxt    = pad_r;
    lane       = '0;
    cmd_valid  = 1'b0;
    cmd.kind   = CMD_PIX;
    cmd.data   = b;
    cmd.ch     = ch_r;
    cmd.done   = done;
    cmd.four   = four_r;
    cmd.last   = last;
    cmd.row    = COORD_W'(row_r);
    cmd.col    = COORD_W'(col_r);

    if (accept) begin
      phase_nxt = phase_c;
      unique case (phase_c)
        PH_HEADER: begin
          if (pos_c == 32'd0) begin
            sig_nxt = b;
          end
          if (pos_c == 32'd1 && !sig_ok(sig_r, b)) begin
            cmd_valid = 1'b1;
            cmd.kind  = CMD_WARN;
          end
          // Little-endian fields: each byte lands in its own lane.
          if (pos_c >= 32'd10 && pos_c <= 32'd13) begin
            lane = 2'(pos_c - 32'd10);
            offset_nxt[8*lane +: 8] = b;
          end
          if (pos_c >= 32'd18 && pos_c <= 32'd21) begin
            lane = 2'(pos_c - 32'd18);
            width_nxt[8*lane +: 8] = b;
          end
          if (pos_c >= 32'd22 && pos_c <= 32'd25) begin
            lane = 2'(pos_c - 32'd22);
            height_nxt[8*lane +: 8] = b;
          end
          if (pos_c == 32'd28) begin
            bpp_nxt = b[7:3];
          end
          if (hdr_end) begin
            if (bad_hdr) begin
              cmd_valid = 1'b1;
              cmd.kind  = CMD_ERR;
              phase_nxt = PH_DONE;
            end else if (empty_img) begin
              phase_nxt = PH_DONE;
            end else begin
              phase_nxt = PH_PIXEL;
              row_nxt   = CW'(height_r - 32'd1);
              col_nxt   = '0;
              ch_nxt    = '0;
              four_nxt  = (bpp_now == 5'd4);
            end
          end else begin
            pos_nxt = pos_c + 32'd1;
          end
        end
        PH_PIXEL: begin
          cmd_valid = 1'b1;
          if (done) begin
            ch_nxt = '0;
            if (col_wrap) begin
              col_nxt = '0;
              if (row_r == '0) begin
                phase_nxt = PH_DONE;
              end else begin
                row_nxt = row_r - 1'b1;
                // Rows of 24-bit images are padded to a multiple of four bytes.
                if (!four_r && width_r[1:0] != 2'd0) begin
                  pad_nxt   = width_r[1:0];
                  phase_nxt = PH_PAD;
                end
              end
            end else begin
              col_nxt = col_inc[CW-1:0];
            end
          end else begin
            ch_nxt = ch_r + 2'd1;
          end
        end
        PH_PAD: begin
          if (pad_r <= 2'd1) begin
            pad_nxt   = '0;
            phase_nxt = PH_PIXEL;
          end else begin
            pad_nxt = pad_r - 2'd1;
          end
        end
        PH_DONE: begin
          phase_nxt = PH_DONE;
        end
        default: begin
          phase_nxt = PH_HEADER;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER;
      pos_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sig_r    <= sig_nxt;
    offset_r <= offset_nxt;
    width_r  <= width_nxt;
    height_r <= height_nxt;
    bpp_r    <= bpp_nxt;
    row_r    <= row_nxt;
    col_r    <= col_nxt;
    ch_r     <= ch_nxt;
    four_r   <= four_nxt;
    pad_r    <= pad_nxt;
  end

endmodule

`default_nettype wire

>>> design/bmp_cmd_fifo.sv
// Short command queue between the parser front and the pixel back.
// Depends on bmp_pkg for the command type and depth.
`timescale 1ns / 1ps
`default_nettype none

module bmp_cmd_fifo import bmp_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  output logic push_ready,
  input  cmd_t push_data,
  output logic pop_valid,
  input  logic pop_ready,
  output cmd_t pop_data
);

  cmd_t                 slot_r [CMD_FIFO_DEPTH];
  logic [CMD_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CMD_PTR_W:0]   count_r, count_nxt;
  logic                 push, pop;

  assign push_ready = (count_r != (CMD_PTR_W+1)'(CMD_FIFO_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = slot_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

>>> design/bmp_back.sv
// Back of the parser: assembles pixel channels and holds the result register.
// Depends on bmp_pkg and bmp_out_if; takes commands from the queue.
`timescale 1ns / 1ps
`default_nettype none

module bmp_back import bmp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cmd_valid,
  output logic       cmd_ready,
  input  cmd_t       cmd,
  bmp_out_if.source  out_ch
);

  logic [CHAN_W-1:0]  hold_b_r, hold_g_r, hold_r_r;
  logic               out_valid_r;
  logic [1:0]         status_r;
  logic [COORD_W-1:0] row_r, col_r;
  logic [CHAN_W-1:0]  red_r, green_r, blue_r, alpha_r;
  logic               has_alpha_r, last_r;
  logic               emit, pop;

  // Warnings, errors and the final byte of a pixel each produce a result beat.
  assign emit      = (cmd.kind != CMD_PIX) || cmd.done;
  assign cmd_ready = !emit || !out_valid_r || out_ch.ready;
  assign pop       = cmd_valid && cmd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && cmd.kind == CMD_PIX && !cmd.done) begin
      unique case (cmd.ch)
        2'd0:    hold_b_r <= cmd.data;
        2'd1:    hold_g_r <= cmd.data;
        2'd2:    hold_r_r <= cmd.data;
        default: hold_r_r <= hold_r_r;
      endcase
    end
    if (pop && emit) begin
      unique case (cmd.kind)
        CMD_PIX: begin
          status_r    <= ST_PIXEL;
          row_r       <= cmd.row;
          col_r       <= cmd.col;
          blue_r      <= hold_b_r;
          green_r     <= hold_g_r;
          red_r       <= cmd.four ? hold_r_r : cmd.data;
          alpha_r     <= cmd.four ? cmd.data : '0;
          has_alpha_r <= cmd.four;
          last_r      <= cmd.last;
        end
        CMD_WARN, CMD_ERR: begin
          status_r    <= (cmd.kind == CMD_WARN) ? ST_BAD_SIG : ST_UNSUPPORTED;
          row_r       <= '0;
          col_r       <= '0;
          blue_r      <= '0;
          green_r     <= '0;
          red_r       <= '0;
          alpha_r     <= '0;
          has_alpha_r <= 1'b0;
          last_r      <= 1'b0;
        end
        default: begin
          status_r <= ST_UNSUPPORTED;
        end
      endcase
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.status     = status_r;
  assign out_ch.row        = row_r;
  assign out_ch.column     = col_r;
  assign out_ch.red        = red_r;
  assign out_ch.green      = green_r;
  assign out_ch.blue       = blue_r;
  assign out_ch.alpha      = alpha_r;
  assign out_ch.has_alpha  = has_alpha_r;
  assign out_ch.last_pixel = last_r;

endmodule

`default_nettype wire

>>> design/bmp_pixel_stream_parser_core.sv
// Channel   Dir  Beat contents
// in_ch     in   file_byte, start_of_file (restart at this byte)
// out_ch    out  status, row, column, red, green, blue, alpha, has_alpha, last_pixel
//
// One file byte is taken per cycle while the command queue has room; a result passes
// through the command queue and then the output register before it is offered.
// The front keeps all parse state, so its rate is set only by the four-entry
// command queue; the back stalls on out_ch.ready without stopping the front
// until that queue fills.
// Reset clears the parse phase, the byte position, the queue and the output valid.
// Top level of the bitmap parser; depends on bmp_pkg, the two interfaces,
// bmp_front, bmp_cmd_fifo and bmp_back.
`timescale 1ns / 1ps
`default_nettype none

module bmp_pixel_stream_parser_core import bmp_pkg::*; #(
  parameter int MAX_DIM = 4096
) (
  input  logic       clk,
  input  logic       rst_n,
  bmp_in_if.sink     in_ch,
  bmp_out_if.source  out_ch
);

  logic cmd_push_valid, cmd_push_ready;
  logic cmd_pop_valid, cmd_pop_ready;
  cmd_t cmd_push, cmd_pop;

  bmp_front #(
    .MAX_DIM (MAX_DIM)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cmd_valid (cmd_push_valid),
    .cmd_ready (cmd_push_ready),
    .cmd       (cmd_push)
  );

  bmp_cmd_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (cmd_push_valid),
    .push_ready (cmd_push_ready),
    .push_data  (cmd_push),
    .pop_valid  (cmd_pop_valid),
    .pop_ready  (cmd_pop_ready),
    .pop_data   (cmd_pop)
  );

  bmp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_pop_valid),
    .cmd_ready (cmd_pop_ready),
    .cmd       (cmd_pop),
    .out_ch    (out_ch)
  );

  // The front must never hand a command to a full queue.
  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_push_valid |-> cmd_push_ready)
    else $error("command pushed into a full queue");

  a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.status == ST_PIXEL || out_ch.status == ST_BAD_SIG ||
                      out_ch.status == ST_UNSUPPORTED))
    else $error("illegal status code on a result beat");

  // Warning and error beats carry no pixel content.
  a_flag_beats_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.status != ST_PIXEL) |->
      (out_ch.row == '0 && out_ch.column == '0 && out_ch.red == '0 &&
       out_ch.has_alpha == 1'b0 && out_ch.last_pixel == 1'b0))
    else $error("status beat carries pixel fields");

  a_alpha_only_32bit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.has_alpha) |-> (out_ch.alpha == '0))
    else $error("alpha set on a 24-bit pixel");

endmodule

`default_nettype wire
